// File: rtl/fifo_queue_search_delete_replace_defines.svh
// Assertion macros for the queue's RTL, included by fqs_ctrl.sv.
`ifndef FIFO_QUEUE_SEARCH_DELETE_REPLACE_DEFINES_SVH
`define FIFO_QUEUE_SEARCH_DELETE_REPLACE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fqs_pkg.sv
// Types, codes and constants shared by the search-and-delete queue.
package fqs_pkg;

  localparam int FQS_QUEUE_DEPTH = 16;
  localparam int FQS_WORD_BITS   = 32;
  localparam int FQS_COUNT_BITS  = 5;

  typedef logic [FQS_WORD_BITS-1:0] fqs_word_t;

  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_MODIFY  = 3'd3,
    OP_CLEAR   = 3'd4
  } fqs_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } fqs_status_t;

  typedef struct packed {
    fqs_op_t   operation;
    fqs_word_t item_word;
    fqs_word_t new_word;
  } fqs_request_t;

  typedef struct packed {
    fqs_word_t                 result_word;
    fqs_status_t               status;
    logic [FQS_COUNT_BITS-1:0] entry_count;
    fqs_word_t                 front_word;
    logic                      front_valid;
  } fqs_result_t;

  // Commands broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic      capture;
    fqs_word_t cap_key;
    logic      shift_all;
    logic      remove;
    logic      replace;
    fqs_word_t repl_word;
    logic      append;
    fqs_word_t app_word;
  } fqs_cell_ctl_t;

endpackage

// File: rtl/fifo_queue_search_delete_replace.sv
// Top level of the bounded word queue with search, delete and replace.
//
//   Channel  Signals                          Direction  Handshake
//   request  start, busy, in_request          in         taken when start is high and busy low
//   result   out_valid, out_result            out        one-cycle strobe, cannot be held off
//
// For each request, at the accepting edge every cell compares its word with the key and
// keeps a match flag; in the following cycle the row shifts, replaces or appends and the
// count is updated. The result is shown in the cycle after that, while busy is already
// low, so a new request may be accepted at the edge that ends the result cycle.
// The sequence follows from the registered match flags of the cell row, not from the depth.
// Reset is synchronous and active low; it empties the queue.
// The result side cannot stall, so every request yields exactly one strobed result.
module fifo_queue_search_delete_replace #(
  parameter int QUEUE_DEPTH = fqs_pkg::FQS_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fqs_pkg::fqs_request_t in_request,
  output logic                 out_valid,
  output fqs_pkg::fqs_result_t out_result
);
  import fqs_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fqs_cell_ctl_t          ctl;
  logic [QUEUE_DEPTH-1:0] cell_valid, cell_append;
  logic [CNT_W-1:0]       count;
  fqs_word_t              res_word;
  fqs_status_t            res_status;

  // Cell words, and two one-bit chains: one runs from the tail towards the head and tells
  // a cell whether a newer entry matched, the other runs from the head towards the tail
  // and tells it whether it sits at or beyond the oldest match.
  fqs_word_t              cell_word [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   above_chain;
  logic [QUEUE_DEPTH:0]   seen_chain;

  assign above_chain[QUEUE_DEPTH] = 1'b0;
  assign seen_chain[0]            = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    fqs_word_t right_word;
    // The last cell has no neighbour; the value it shifts in is never read as an entry.
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_word = cell_word[i];
    end else begin : g_body
      assign right_word = cell_word[i+1];
    end

    fqs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .valid_in   (cell_valid[i]),
      .append_in  (cell_append[i]),
      .right_word (right_word),
      .above_in   (above_chain[i+1]),
      .seen_in    (seen_chain[i]),
      .word       (cell_word[i]),
      .above_out  (above_chain[i]),
      .seen_out   (seen_chain[i+1])
    );
  end

  fqs_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req         (in_request),
    .hit         (above_chain[0]),
    .head_word   (cell_word[0]),
    .busy        (busy),
    .ctl         (ctl),
    .cell_valid  (cell_valid),
    .cell_append (cell_append),
    .count       (count),
    .res_valid   (out_valid),
    .res_word    (res_word),
    .res_status  (res_status)
  );

  // The count and the head cell already hold the state after the request.
  always_comb begin
    out_result.result_word = res_word;
    out_result.status      = res_status;
    out_result.entry_count = FQS_COUNT_BITS'(count);
    out_result.front_valid = (count != '0);
    out_result.front_word  = (count != '0) ? cell_word[0] : '0;
  end

endmodule

// File: rtl/fqs_cell.sv
// One storage cell of the queue row: holds a word and its match flag.
module fqs_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fqs_pkg::fqs_cell_ctl_t ctl,
  input  logic                  valid_in,
  input  logic                  append_in,
  input  fqs_pkg::fqs_word_t    right_word,
  input  logic                  above_in,
  input  logic                  seen_in,
  output fqs_pkg::fqs_word_t    word,
  output logic                  above_out,
  output logic                  seen_out
);
  import fqs_pkg::*;

  fqs_word_t word_r, word_nxt;
  logic      match_r, match_nxt;
  logic      take_right, put_repl;

  // The newest match is the matching cell with no match further towards the tail.
  assign above_out  = above_in | match_r;
  assign seen_out   = seen_in | match_r;
  assign take_right = ctl.shift_all | (ctl.remove & ~above_in & seen_out);
  assign put_repl   = ctl.replace & match_r & ~above_in;
  assign word       = word_r;

  always_comb begin
    word_nxt  = word_r;
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = valid_in && (word_r == ctl.cap_key);
    end
    if (take_right) begin
      word_nxt = right_word;
    end else if (put_repl) begin
      word_nxt = ctl.repl_word;
    end else if (ctl.append && append_in) begin
      word_nxt = ctl.app_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

// File: rtl/fqs_ctrl.sv
// Sequencer of the queue: holds the count, decodes requests and forms results.
`include "fifo_queue_search_delete_replace_defines.svh"

module fqs_ctrl #(
  parameter int QUEUE_DEPTH = fqs_pkg::FQS_QUEUE_DEPTH,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  fqs_pkg::fqs_request_t  req,
  input  logic                   hit,
  input  fqs_pkg::fqs_word_t     head_word,
  output logic                   busy,
  output fqs_pkg::fqs_cell_ctl_t ctl,
  output logic [QUEUE_DEPTH-1:0] cell_valid,
  output logic [QUEUE_DEPTH-1:0] cell_append,
  output logic [CNT_W-1:0]       count,
  output logic                   res_valid,
  output fqs_pkg::fqs_word_t     res_word,
  output fqs_pkg::fqs_status_t   res_status
);
  import fqs_pkg::*;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  fqs_op_t     op_r;
  fqs_word_t   key_r, repl_r;
  logic        out_valid_r, out_valid_nxt;
  fqs_word_t   res_word_r, res_word_nxt;
  fqs_status_t status_r, status_nxt;
  logic        accept, full, empty;

  assign accept = start && (state_r == IDLE);
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_pos
    assign cell_valid[i]  = (count_r > CNT_W'(i));
    assign cell_append[i] = (count_r == CNT_W'(i));
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    res_word_nxt  = res_word_r;
    status_nxt    = status_r;
    ctl           = '0;
    ctl.capture   = accept;
    ctl.cap_key   = req.item_word;
    ctl.repl_word = repl_r;
    unique case (state_r)
      IDLE: begin
        if (accept) begin
          state_nxt = EXEC;
        end
      end
      EXEC: begin
        state_nxt     = IDLE;
        out_valid_nxt = 1'b1;
        res_word_nxt  = '0;
        status_nxt    = ST_OK;
        case (op_r)
          OP_ENQUEUE: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.append   = 1'b1;
              ctl.app_word = key_r;
              count_nxt    = count_r + 1'b1;
            end
          end
          OP_DEQUEUE: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              ctl.shift_all = 1'b1;
              res_word_nxt  = head_word;
              count_nxt     = count_r - 1'b1;
            end
          end
          OP_REMOVE: begin
            // A matching entry always equals the key, so the key is the removed word.
            if (hit) begin
              ctl.remove   = 1'b1;
              res_word_nxt = key_r;
              count_nxt    = count_r - 1'b1;
            end else begin
              status_nxt = ST_NOMATCH;
            end
          end
          OP_MODIFY: begin
            if (hit) begin
              ctl.replace  = 1'b1;
              res_word_nxt = key_r;
            end else begin
              res_word_nxt = repl_r;
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.append   = 1'b1;
                ctl.app_word = repl_r;
                count_nxt    = count_r + 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      op_r   <= req.operation;
      key_r  <= req.item_word;
      repl_r <= req.new_word;
    end
    res_word_r <= res_word_nxt;
    status_r   <= status_nxt;
  end

  assign busy       = (state_r == EXEC);
  assign count      = count_r;
  assign res_valid  = out_valid_r;
  assign res_word   = res_word_r;
  assign res_status = status_r;

  `FQS_ASSERT_NEXT(a_result_follows_exec, state_r == EXEC, out_valid_r, "no result after execution")
  `FQS_ASSERT_NOW(a_count_in_range, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
  `FQS_ASSERT_NEXT(a_accept_goes_busy, accept, busy && !out_valid_r, "accepted request not executing")
  `FQS_ASSERT_NEXT(a_count_steps_by_one, state_r == EXEC && op_r != OP_CLEAR, count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 || count_r == $past(count_r) - 1'b1, "count moved by more than one")
  `FQS_ASSERT_NOW(a_full_no_growth, out_valid_r && status_r == ST_FULL, count_r == CNT_W'(QUEUE_DEPTH), "full status while not full")

endmodule
